FILE: hw/rtl/nidg_pkg.sv
`default_nettype none

package nidg_pkg;

	localparam int DevCount = 48;
	localparam int CodeW    = 8;
	localparam int IdxW     = 6;

	localparam logic [7:0] CELL_MASK = 8'h0C;
	localparam logic [7:0] MAKER_A   = 8'hEC;
	localparam logic [7:0] MAKER_B   = 8'hAD;

	// device table: code, page bytes (0 = geometry from the extended ID), size in MiB,
	// erase bytes and address cycles
	localparam logic [7:0] DEV_CODE [DevCount] = '{
		8'h6E, 8'h64, 8'h6B, 8'hE8, 8'hEC, 8'hEA, 8'hD5, 8'hE3,
		8'hE5, 8'hD6, 8'h39, 8'hE6, 8'h33, 8'h73, 8'h35, 8'h75,
		8'h36, 8'h76, 8'h78, 8'h39, 8'h79, 8'h71, 8'hA2, 8'hA0,
		8'hF2, 8'hD0, 8'hF0, 8'hA1, 8'hF1, 8'hD1, 8'hAA, 8'hDA,
		8'hAC, 8'hDC, 8'hA3, 8'hD3, 8'hA5, 8'hD5, 8'hA7, 8'hD7,
		8'hAE, 8'hDE, 8'h1A, 8'h3A, 8'h1C, 8'h3C, 8'h1E, 8'h3E
	};

	localparam logic [9:0] DEV_PAGE [DevCount] = '{
		10'd256, 10'd256, 10'd512, 10'd256, 10'd256, 10'd256, 10'd512, 10'd512,
		10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512,
		10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd0,   10'd0,
		10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
		10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
		10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0
	};

	localparam logic [16:0] DEV_CHIP [DevCount] = '{
		17'd1,     17'd2,     17'd4,     17'd1,     17'd1,     17'd2,     17'd4,     17'd4,
		17'd4,     17'd8,     17'd8,     17'd8,     17'd16,    17'd16,    17'd32,    17'd32,
		17'd64,    17'd64,    17'd128,   17'd128,   17'd128,   17'd256,   17'd64,    17'd64,
		17'd64,    17'd64,    17'd64,    17'd128,   17'd128,   17'd128,   17'd256,   17'd256,
		17'd512,   17'd512,   17'd1024,  17'd1024,  17'd2048,  17'd2048,  17'd4096,  17'd4096,
		17'd8192,  17'd8192,  17'd16384, 17'd16384, 17'd32768, 17'd32768, 17'd65536, 17'd65536
	};

	localparam logic [14:0] DEV_ERASE [DevCount] = '{
		15'h1000, 15'h1000, 15'h2000, 15'h1000, 15'h1000, 15'h1000, 15'h2000, 15'h2000,
		15'h2000, 15'h2000, 15'h2000, 15'h2000, 15'h4000, 15'h4000, 15'h4000, 15'h4000,
		15'h4000, 15'h4000, 15'h4000, 15'h4000, 15'h4000, 15'h4000, 15'h0,    15'h0,
		15'h0,    15'h0,    15'h0,    15'h0,    15'h0,    15'h0,    15'h0,    15'h0,
		15'h0,    15'h0,    15'h0,    15'h0,    15'h0,    15'h0,    15'h0,    15'h0,
		15'h0,    15'h0,    15'h0,    15'h0,    15'h0,    15'h0,    15'h0,    15'h0
	};

	localparam logic [2:0] DEV_CYC [DevCount] = '{
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
		3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6
	};

	typedef struct packed {
		logic        known;
		logic [5:0]  idx;
		logic [16:0] chip_mb;
		logic [9:0]  page;
		logic [14:0] erase;
		logic        lp;
		logic [2:0]  cyc;
	} dev_entry_t;

	typedef struct packed {
		dev_entry_t  ent;
		logic [7:0]  maker;
		logic [7:0]  cell_type;
		logic [7:0]  ext;
		logic [7:0]  b5;
		logic [3:0]  id_len;
	} lkp_t;

	typedef struct packed {
		logic        known;
		logic [5:0]  table_index;
		logic [16:0] chip_size_mb;
		logic        large_page;
		logic [14:0] page_size;
		logic [9:0]  spare_size;
		logic [24:0] erase_size;
		logic        bus_16bit;
		logic [2:0]  addr_cycles;
		logic [3:0]  id_length;
	} geo_t;

	// first matching entry wins: scan from the top so the lowest index overwrites
	function automatic dev_entry_t dev_lookup(input logic [CodeW-1:0] code);
		dev_entry_t e;
		e = '0;
		for (int i = DevCount - 1; i >= 0; i--) begin
			if (DEV_CODE[i] == code) begin
				e.known   = 1'b1;
				e.idx     = IdxW'(i);
				e.chip_mb = DEV_CHIP[i];
				e.page    = DEV_PAGE[i];
				e.erase   = DEV_ERASE[i];
				e.lp      = (DEV_PAGE[i] == 10'd0);
				e.cyc     = DEV_CYC[i];
			end
		end
		return e;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nidg_if.sv
`default_nettype none

interface nidg_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] id_byte_0;
	logic [7:0] id_byte_1;
	logic [7:0] id_byte_2;
	logic [7:0] id_byte_3;
	logic [7:0] id_byte_4;
	logic [7:0] id_byte_5;
	logic [7:0] id_byte_6;
	logic [7:0] id_byte_7;

	modport source (output valid, id_byte_0, id_byte_1, id_byte_2, id_byte_3,
		id_byte_4, id_byte_5, id_byte_6, id_byte_7, input ready);
	modport sink (input valid, id_byte_0, id_byte_1, id_byte_2, id_byte_3,
		id_byte_4, id_byte_5, id_byte_6, id_byte_7, output ready);
endinterface

interface nidg_out_if;
	logic        valid;
	logic        ready;
	logic        known;
	logic [5:0]  table_index;
	logic [16:0] chip_size_mb;
	logic        large_page;
	logic [14:0] page_size;
	logic [9:0]  spare_size;
	logic [24:0] erase_size;
	logic        bus_16bit;
	logic [2:0]  addr_cycles;
	logic [3:0]  id_length;

	modport source (output valid, known, table_index, chip_size_mb, large_page, page_size,
		spare_size, erase_size, bus_16bit, addr_cycles, id_length, input ready);
	modport sink (input valid, known, table_index, chip_size_mb, large_page, page_size,
		spare_size, erase_size, bus_16bit, addr_cycles, id_length, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nand_id_geometry_decoder.sv
`default_nettype none

// Channel  Direction  Contents
// id_in    sink       eight read-ID bytes, id_byte_0 .. id_byte_7
// geo_out  source     known flag, table index, size, page/spare/erase, bus, cycles, ID length
//
// One transaction per cycle while geo_out is not stalled; a registered table read, then
// a registered geometry decode, lie between acceptance and the result showing on geo_out.
// Reset clears the stage valids only; there is no other state.
// A stalled result holds the whole pipe: id_in.ready drops only while geo_out holds
// a result that is not taken.

module nand_id_geometry_decoder (
	input wire logic   clk,
	input wire logic   arst_n,
	nidg_in_if.sink    id_in,
	nidg_out_if.source geo_out
);

	nidg_pkg::lkp_t lkp_s1;
	nidg_pkg::geo_t geo_d;
	nidg_pkg::geo_t geo_s2;
	logic           v_s1;
	logic           v_s2;
	logic           adv;

	// advance while the output slot is free or being emptied
	assign adv         = !v_s2 || geo_out.ready;
	assign id_in.ready = adv;

	nidg_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.take     (id_in.valid),
		.id_bytes ({id_in.id_byte_7, id_in.id_byte_6, id_in.id_byte_5, id_in.id_byte_4,
			id_in.id_byte_3, id_in.id_byte_2, id_in.id_byte_1, id_in.id_byte_0}),
		.lkp_s1   (lkp_s1),
		.v_s1     (v_s1)
	);

	nidg_geom u_geom (
		.lkp (lkp_s1),
		.geo (geo_d)
	);

	always_ff @(posedge clk) begin
		if (adv)
			geo_s2 <= geo_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	assign geo_out.valid        = v_s2;
	assign geo_out.known        = geo_s2.known;
	assign geo_out.table_index  = geo_s2.table_index;
	assign geo_out.chip_size_mb = geo_s2.chip_size_mb;
	assign geo_out.large_page   = geo_s2.large_page;
	assign geo_out.page_size    = geo_s2.page_size;
	assign geo_out.spare_size   = geo_s2.spare_size;
	assign geo_out.erase_size   = geo_s2.erase_size;
	assign geo_out.bus_16bit    = geo_s2.bus_16bit;
	assign geo_out.addr_cycles  = geo_s2.addr_cycles;
	assign geo_out.id_length    = geo_s2.id_length;

endmodule

`default_nettype wire

FILE: hw/rtl/nidg_lookup.sv
`default_nettype none

module nidg_lookup (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          take,
	input  wire logic [63:0]   id_bytes,
	output nidg_pkg::lkp_t     lkp_s1,
	output logic               v_s1
);

	// smallest wraparound period, else trimmed length, else 8; zero for an all-zero ID
	function automatic logic [3:0] id_len_f(input logic [7:0][7:0] b);
		logic [3:0] len;
		logic       ok;
		logic       any;
		len = 4'd8;
		any = 1'b0;
		if (b[7] == 8'd0) begin
			for (int i = 0; i < 7; i++) begin
				if (b[i] != 8'd0)
					len = 4'(i + 1);
			end
		end
		for (int p = 7; p >= 1; p--) begin
			ok = 1'b1;
			for (int i = 0; i < 8 - p; i++) begin
				if (b[i] != b[i + p])
					ok = 1'b0;
			end
			if (ok)
				len = 4'(p);
		end
		for (int i = 0; i < 8; i++)
			any = any | (b[i] != 8'd0);
		if (!any)
			len = 4'd0;
		return len;
	endfunction

	logic [7:0][7:0] b;

	assign b = id_bytes;

	// table read: registered
	always_ff @(posedge clk) begin
		if (adv) begin
			lkp_s1.ent       <= nidg_pkg::dev_lookup(b[1]);
			lkp_s1.maker     <= b[0];
			lkp_s1.cell_type <= b[2];
			lkp_s1.ext       <= b[3];
			lkp_s1.b5        <= b[5];
			lkp_s1.id_len    <= id_len_f(b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/nidg_geom.sv
`default_nettype none

module nidg_geom (
	input  nidg_pkg::lkp_t lkp,
	output nidg_pkg::geo_t geo
);

	logic        is_mlc;
	logic        br_a;
	logic        br_b;
	logic [2:0]  s_spare;
	logic [2:0]  s_erase;
	logic [7:0]  ext;
	logic [14:0] page;
	logic [9:0]  spare;
	logic [24:0] erase;
	logic        bus;

	assign ext     = lkp.ext;
	assign is_mlc  = (lkp.cell_type & nidg_pkg::CELL_MASK) != 8'd0;
	assign br_a    = (lkp.id_len == 4'd6) && (lkp.maker == nidg_pkg::MAKER_A) && is_mlc
		&& (lkp.b5 != 8'd0);
	assign br_b    = (lkp.id_len == 4'd6) && (lkp.maker == nidg_pkg::MAKER_B) && is_mlc;
	assign s_spare = {ext[6], ext[3:2]};
	assign s_erase = {ext[7], ext[5:4]};

	always_comb begin
		bus = 1'b0;
		if (lkp.ent.page != 10'd0) begin
			page  = 15'(lkp.ent.page);
			erase = 25'(lkp.ent.erase);
			spare = 10'(lkp.ent.page >> 5);
		end else if (br_a) begin
			page  = 15'd2048 << ext[1:0];
			erase = 25'(128 * 1024) << s_erase;
			case (ext[3:2])
				2'd1:    spare = 10'd128;
				2'd2:    spare = 10'd218;
				2'd3:    spare = 10'd400;
				default: spare = 10'd436;
			endcase
		end else if (br_b) begin
			page = 15'd2048 << ext[1:0];
			case (s_spare)
				3'd0:    spare = 10'd128;
				3'd1:    spare = 10'd224;
				3'd2:    spare = 10'd448;
				3'd3:    spare = 10'd64;
				3'd4:    spare = 10'd32;
				3'd5:    spare = 10'd16;
				default: spare = 10'd640;
			endcase
			if (s_erase < 3'd3)
				erase = 25'(128 * 1024) << s_erase;
			else if (s_erase == 3'd3)
				erase = 25'(768 * 1024);
			else
				erase = 25'(64 * 1024) << s_erase;
		end else begin
			page  = 15'd1024 << ext[1:0];
			// (8 or 16) times page/512
			spare = (ext[2] ? 10'd32 : 10'd16) << ext[1:0];
			erase = 25'(64 * 1024) << ext[5:4];
			bus   = ext[6];
		end
	end

	// unknown code: flag low, everything else zero
	always_comb begin
		geo = '0;
		if (lkp.ent.known) begin
			geo.known        = 1'b1;
			geo.table_index  = lkp.ent.idx;
			geo.chip_size_mb = lkp.ent.chip_mb;
			geo.large_page   = lkp.ent.lp;
			geo.page_size    = page;
			geo.spare_size   = spare;
			geo.erase_size   = erase;
			geo.bus_16bit    = bus;
			geo.addr_cycles  = lkp.ent.cyc;
			geo.id_length    = lkp.id_len;
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/nand_id_geometry_decoder_tb.sv
module nand_id_geometry_decoder_tb;

	typedef bit [0:7][7:0] id_bytes_t;

	typedef struct packed {
		logic        known;
		logic [5:0]  table_index;
		logic [16:0] chip_size_mb;
		logic        large_page;
		logic [14:0] page_size;
		logic [9:0]  spare_size;
		logic [24:0] erase_size;
		logic        bus_16bit;
		logic [2:0]  addr_cycles;
		logic [3:0]  id_length;
	} geometry_t;

	typedef struct packed {
		id_bytes_t id;
		geometry_t geo;
	} expected_geo_t;

	class geometry_scoreboard;
		localparam int DEV_COUNT = 48;
		localparam int OLD_COUNT = 22;

		localparam bit [0:47][7:0] DEV_CODES = {
			8'h6E, 8'h64, 8'h6B, 8'hE8, 8'hEC, 8'hEA, 8'hD5, 8'hE3,
			8'hE5, 8'hD6, 8'h39, 8'hE6, 8'h33, 8'h73, 8'h35, 8'h75,
			8'h36, 8'h76, 8'h78, 8'h39, 8'h79, 8'h71, 8'hA2, 8'hA0,
			8'hF2, 8'hD0, 8'hF0, 8'hA1, 8'hF1, 8'hD1, 8'hAA, 8'hDA,
			8'hAC, 8'hDC, 8'hA3, 8'hD3, 8'hA5, 8'hD5, 8'hA7, 8'hD7,
			8'hAE, 8'hDE, 8'h1A, 8'h3A, 8'h1C, 8'h3C, 8'h1E, 8'h3E};

		localparam bit [0:47][16:0] DEV_MIB = {
			17'd1, 17'd2, 17'd4, 17'd1, 17'd1, 17'd2, 17'd4, 17'd4,
			17'd4, 17'd8, 17'd8, 17'd8, 17'd16, 17'd16, 17'd32, 17'd32,
			17'd64, 17'd64, 17'd128, 17'd128, 17'd128, 17'd256, 17'd64, 17'd64,
			17'd64, 17'd64, 17'd64, 17'd128, 17'd128, 17'd128, 17'd256, 17'd256,
			17'd512, 17'd512, 17'd1024, 17'd1024, 17'd2048, 17'd2048, 17'd4096, 17'd4096,
			17'd8192, 17'd8192, 17'd16384, 17'd16384, 17'd32768, 17'd32768,
			17'd65536, 17'd65536};

		localparam bit [0:47][2:0] DEV_ADDR_CYC = {
			3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
			3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
			3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
			3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5,
			3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
			3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6};

		// only the old small-page parts carry fixed page and erase sizes
		localparam bit [0:21][9:0] OLD_PAGE = {
			10'd256, 10'd256, 10'd512, 10'd256, 10'd256, 10'd256, 10'd512, 10'd512,
			10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512,
			10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512};

		localparam bit [0:21][14:0] OLD_ERASE = {
			15'd4096, 15'd4096, 15'd8192, 15'd4096, 15'd4096, 15'd4096, 15'd8192, 15'd8192,
			15'd8192, 15'd8192, 15'd8192, 15'd8192, 15'd16384, 15'd16384, 15'd16384,
			15'd16384, 15'd16384, 15'd16384, 15'd16384, 15'd16384, 15'd16384, 15'd16384};

		expected_geo_t expected_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function bit [7:0] random_code();
			return DEV_CODES[$urandom_range(0, DEV_COUNT - 1)];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// smallest wraparound period, else length with trailing zeros trimmed
		static function int unsigned id_length_of(id_bytes_t b);
			int last;
			bit periodic;
			last = 7;
			while (last >= 0 && b[last] == 8'h00)
				last--;
			if (last < 0)
				return 0;
			for (int p = 1; p < 8; p++) begin
				periodic = 1'b1;
				for (int j = p; j < 8; j++)
					if (b[j] != b[j - p])
						periodic = 1'b0;
				if (periodic)
					return p;
			end
			if (last < 7)
				return last + 1;
			return 8;
		endfunction

		static function geometry_t decode_id(id_bytes_t b);
			geometry_t g;
			int idx;
			int unsigned len, page, spare, erase;
			bit [7:0] ext;
			bit [2:0] sel;
			bit bus;
			g = '0;
			idx = DEV_COUNT;
			for (int i = DEV_COUNT - 1; i >= 0; i--)
				if (DEV_CODES[i] == b[1])
					idx = i;
			if (idx == DEV_COUNT)
				return g;
			len = id_length_of(b);
			ext = b[3];
			bus = 1'b0;
			if (idx < OLD_COUNT) begin
				page = OLD_PAGE[idx];
				erase = OLD_ERASE[idx];
				spare = page / 32;
			end else if (len == 6 && b[0] == nidg_pkg::MAKER_A
					&& (b[2] & nidg_pkg::CELL_MASK) != 0 && b[5] != 8'h00) begin
				page = 2048 << ext[1:0];
				case (ext[3:2])
					2'd1: spare = 128;
					2'd2: spare = 218;
					2'd3: spare = 400;
					default: spare = 436;
				endcase
				sel = {ext[7], ext[5:4]};
				erase = (128 * 1024) << sel;
			end else if (len == 6 && b[0] == nidg_pkg::MAKER_B
					&& (b[2] & nidg_pkg::CELL_MASK) != 0) begin
				page = 2048 << ext[1:0];
				sel = {ext[6], ext[3:2]};
				case (sel)
					3'd0: spare = 128;
					3'd1: spare = 224;
					3'd2: spare = 448;
					3'd3: spare = 64;
					3'd4: spare = 32;
					3'd5: spare = 16;
					default: spare = 640;
				endcase
				sel = {ext[7], ext[5:4]};
				if (sel < 3'd3)
					erase = (128 * 1024) << sel;
				else if (sel == 3'd3)
					erase = 768 * 1024;
				else
					erase = (64 * 1024) << sel;
			end else begin
				page = 1024 << ext[1:0];
				spare = (8 << ext[2]) * (page >> 9);
				erase = (64 * 1024) << ext[5:4];
				bus = ext[6];
			end
			g.known = 1'b1;
			g.table_index = 6'(idx);
			g.chip_size_mb = DEV_MIB[idx];
			g.large_page = (idx >= OLD_COUNT);
			g.page_size = 15'(page);
			g.spare_size = 10'(spare);
			g.erase_size = 25'(erase);
			g.bus_16bit = bus;
			g.addr_cycles = DEV_ADDR_CYC[idx];
			g.id_length = 4'(len);
			return g;
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		function string field_msg(string name, id_bytes_t id, logic [31:0] got,
				logic [31:0] exp);
			return $sformatf("id %h %s got %0d expected %0d", id, name, got, exp);
		endfunction

		function void note_id(id_bytes_t id);
			expected_geo_t e;
			e.id = id;
			e.geo = decode_id(id);
			expected_q.push_back(e);
		endfunction

		task check_geometry(geometry_t got);
			expected_geo_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing outstanding, index %0d",
					got.table_index));
				return;
			end
			e = expected_q.pop_front();
			if (got.known !== e.geo.known)
				report(field_msg("known", e.id, got.known, e.geo.known));
			if (got.table_index !== e.geo.table_index)
				report(field_msg("table_index", e.id, got.table_index, e.geo.table_index));
			if (got.chip_size_mb !== e.geo.chip_size_mb)
				report(field_msg("chip_size_mb", e.id, got.chip_size_mb, e.geo.chip_size_mb));
			if (got.large_page !== e.geo.large_page)
				report(field_msg("large_page", e.id, got.large_page, e.geo.large_page));
			if (got.page_size !== e.geo.page_size)
				report(field_msg("page_size", e.id, got.page_size, e.geo.page_size));
			if (got.spare_size !== e.geo.spare_size)
				report(field_msg("spare_size", e.id, got.spare_size, e.geo.spare_size));
			if (got.erase_size !== e.geo.erase_size)
				report(field_msg("erase_size", e.id, got.erase_size, e.geo.erase_size));
			if (got.bus_16bit !== e.geo.bus_16bit)
				report(field_msg("bus_16bit", e.id, got.bus_16bit, e.geo.bus_16bit));
			if (got.addr_cycles !== e.geo.addr_cycles)
				report(field_msg("addr_cycles", e.id, got.addr_cycles, e.geo.addr_cycles));
			if (got.id_length !== e.geo.id_length)
				report(field_msg("id_length", e.id, got.id_length, e.geo.id_length));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int snd_idle_pct = 33;
	int rcv_idle_pct = 45;
	geometry_scoreboard sb;
	id_bytes_t directed_ids [25];

	nidg_in_if id_in();
	nidg_out_if geo_out();

	nand_id_geometry_decoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.id_in   (id_in),
		.geo_out (geo_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		geo_out.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin : sample_channels
		geometry_t got;
		if (arst_n === 1'b1) begin
			if (id_in.valid && id_in.ready)
				sb.note_id({id_in.id_byte_0, id_in.id_byte_1, id_in.id_byte_2,
					id_in.id_byte_3, id_in.id_byte_4, id_in.id_byte_5,
					id_in.id_byte_6, id_in.id_byte_7});
			if (geo_out.valid && geo_out.ready) begin
				got.known = geo_out.known;
				got.table_index = geo_out.table_index;
				got.chip_size_mb = geo_out.chip_size_mb;
				got.large_page = geo_out.large_page;
				got.page_size = geo_out.page_size;
				got.spare_size = geo_out.spare_size;
				got.erase_size = geo_out.erase_size;
				got.bus_16bit = geo_out.bus_16bit;
				got.addr_cycles = geo_out.addr_cycles;
				got.id_length = geo_out.id_length;
				sb.check_geometry(got);
			end
		end
	end

	// six-byte ID that wraps around after byte 5
	function automatic id_bytes_t six_wrap(bit [7:0] m, bit [7:0] d, bit [7:0] c,
			bit [7:0] x, bit [7:0] b4, bit [7:0] b5);
		return {m, d, c, x, b4, b5, m, d};
	endfunction

	function automatic id_bytes_t random_id();
		id_bytes_t b;
		int p;
		int n;
		int shape;
		for (int i = 0; i < 8; i++)
			b[i] = 8'($urandom);
		// a fifth of the traffic is raw noise, mostly unknown device codes
		if ($urandom_range(0, 99) < 20)
			return b;
		b[1] = sb.random_code();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: b[0] = nidg_pkg::MAKER_A;
			4, 5, 6, 7: b[0] = nidg_pkg::MAKER_B;
			default: ;
		endcase
		if ($urandom_range(0, 9) == 0)
			b[5] = 8'h00;
		shape = $urandom_range(0, 9);
		if (shape <= 5) begin
			b[6] = b[0];
			b[7] = b[1];
		end else if (shape <= 7) begin
			n = $urandom_range(1, 7);
			for (int i = n; i < 8; i++)
				b[i] = 8'h00;
		end else if (shape == 8) begin
			p = $urandom_range(1, 7);
			for (int i = p; i < 8; i++)
				b[i] = b[i - p];
		end
		return b;
	endfunction

	task automatic drive_bytes(input id_bytes_t b);
		id_in.id_byte_0 = b[0];
		id_in.id_byte_1 = b[1];
		id_in.id_byte_2 = b[2];
		id_in.id_byte_3 = b[3];
		id_in.id_byte_4 = b[4];
		id_in.id_byte_5 = b[5];
		id_in.id_byte_6 = b[6];
		id_in.id_byte_7 = b[7];
	endtask

	task automatic send_id(input id_bytes_t b);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			id_in.valid = 1'b0;
			drive_bytes({$urandom, $urandom});
			@(negedge clk);
		end
		id_in.valid = 1'b1;
		drive_bytes(b);
		@(posedge clk);
		while (!id_in.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold the sender off until every outstanding result is back
	task automatic drain();
		id_in.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		#2000000;
		$display("nand_id_geometry_decoder test failed");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		id_in.valid = 1'b0;
		drive_bytes('0);
		geo_out.ready = 1'b0;
		directed_ids = '{
			{8{8'h00}},
			{8{8'hFF}},
			{8'h98, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
			{8'hEC, 8'h39, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66},
			{8'hEC, 8'hD5, 8'h14, 8'hB6, 8'h74, 8'h42, 8'h00, 8'h00},
			six_wrap(nidg_pkg::MAKER_A, 8'hD7, 8'h94, 8'hB6, 8'h74, 8'h42),
			six_wrap(nidg_pkg::MAKER_A, 8'hD7, 8'h04, 8'h03, 8'h74, 8'h42),
			six_wrap(nidg_pkg::MAKER_A, 8'hD7, 8'h94, 8'h29, 8'h72, 8'h00),
			six_wrap(nidg_pkg::MAKER_A, 8'hDA, 8'h10, 8'h95, 8'h44, 8'h42),
			six_wrap(nidg_pkg::MAKER_B, 8'hD7, 8'h14, 8'h30, 8'h74, 8'h42),
			six_wrap(nidg_pkg::MAKER_B, 8'hD7, 8'h08, 8'h4C, 8'h74, 8'h00),
			six_wrap(nidg_pkg::MAKER_B, 8'hDE, 8'h14, 8'hC5, 8'h74, 8'h42),
			six_wrap(nidg_pkg::MAKER_B, 8'hA3, 8'h0C, 8'hF3, 8'h74, 8'h42),
			{nidg_pkg::MAKER_B, 8'hD3, 8'h14, 8'hDE, 8'h74, 8'h00, 8'h00, 8'h00},
			{8'h98, 8'hF1, 8'h80, 8'h55, 8'h40, 8'h00, 8'h00, 8'h00},
			{8{8'hD3}},
			{4{8'h2C, 8'hDA}},
			{8'h20, 8'hF1, 8'h00, 8'h20, 8'hF1, 8'h00, 8'h20, 8'hF1},
			{8'h98, 8'hDC, 8'h90, 8'h26, 8'h76, 8'h15, 8'h01, 8'h98},
			{8'hEC, 8'hD3, 8'h51, 8'h95, 8'h58, 8'h21, 8'h33, 8'h44},
			six_wrap(nidg_pkg::MAKER_B, 8'h3E, 8'h14, 8'h03, 8'h74, 8'h42),
			six_wrap(nidg_pkg::MAKER_A, 8'h1A, 8'h84, 8'h00, 8'h74, 8'h42),
			six_wrap(nidg_pkg::MAKER_A, 8'hDE, 8'hD5, 8'hFF, 8'h74, 8'h42),
			{8'hEC, 8'h00, 8'h51, 8'h95, 8'h58, 8'h21, 8'h00, 8'h00},
			{8'h20, 8'h71, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_ids[i])
			send_id(directed_ids[i]);
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					snd_idle_pct = 33;
					rcv_idle_pct = 45;
				end
				1: begin
					snd_idle_pct = 45;
					rcv_idle_pct = 33;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < 425; n++)
				send_id(random_id());
			drain();
		end

		// let any stray result surface before closing
		repeat (10) @(negedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("nand_id_geometry_decoder test passed");
		else
			$display("nand_id_geometry_decoder test failed");
		$finish;
	end
endmodule
